/* rtl/phe_pkg.sv */
// ----------------------------------------------------------------------------
// phe_pkg
// Shared types and constants for the Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package phe_pkg;

  // Data and configuration widths
  localparam int DATA_W     = 32;
  localparam int DEG_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SEL_W      = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_BASE  = 3'd1;

  typedef logic signed [DATA_W-1:0] data_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;      // capture time, seed accumulator
    logic             mul;       // register acc * time
    logic             add;       // accumulate with saturation
    logic             out_load;  // move accumulator to output register
    logic [SEL_W-1:0] sel;       // coefficient select
  } phe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [DEG_W-1:0] degree;    // configured degree, unclamped
  } phe_stat_t;

endpackage

/* rtl/phe_if.sv */
// ----------------------------------------------------------------------------
// phe_sample_if / phe_result_if
// Valid/ready channels for evaluation requests and results.
// ----------------------------------------------------------------------------
interface phe_sample_if;
  import phe_pkg::*;

  logic  valid;
  logic  ready;
  data_t eval_time;

  modport source (output valid, output eval_time, input ready);
  modport sink   (input valid, input eval_time, output ready);
endinterface

interface phe_result_if;
  import phe_pkg::*;

  logic  valid;
  logic  ready;
  data_t poly_value;
  logic  saturated;

  modport source (output valid, output poly_value, output saturated, input ready);
  modport sink   (input valid, input poly_value, input saturated, output ready);
endinterface

/* rtl/phe_dp.sv */
// ----------------------------------------------------------------------------
// phe_dp
// Datapath: config registers, shared multiplier, saturating accumulator and
// output register.
// ----------------------------------------------------------------------------
module phe_dp #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [phe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  phe_pkg::data_t                 eval_time,
  input  phe_pkg::phe_cmd_t              cmd,
  output phe_pkg::phe_stat_t             stat,
  output phe_pkg::data_t                 poly_value,
  output logic                           saturated
);
  import phe_pkg::*;

  localparam int NCOEF  = MAX_DEGREE + 1;
  localparam int CIDX_W = $clog2(NCOEF);

  logic [DEG_W-1:0]         poly_degree;
  data_t                    coeff [NCOEF];
  data_t                    t_reg;
  data_t                    acc;
  logic                     flag;
  logic signed [2*DATA_W-1:0] prod;

  data_t                    coef_sel;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic signed [2*DATA_W:0]   sum;
  logic [2*DATA_W-DATA_W+1:0] sum_hi;
  logic                     in_range;
  data_t                    sum_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poly_degree <= '0;
      for (int k = 0; k < NCOEF; k++) begin
        coeff[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_POLY_DEGREE) begin
        poly_degree <= cfg_data[DEG_W-1:0];
      end
      for (int k = 0; k < NCOEF; k++) begin
        if (cfg_index == CFG_IDX_W'(REG_COEFF_BASE + k)) begin
          coeff[k] <= cfg_data;
        end
      end
    end
  end

  assign stat.degree = poly_degree;

  // Coefficient select, scaled product, exact sum and saturation
  assign coef_sel = coeff[cmd.sel[CIDX_W-1:0]];
  assign prod_sh  = prod >>> FRAC_BITS;
  assign sum      = (2*DATA_W+1)'(coef_sel) + (2*DATA_W+1)'(prod_sh);
  assign sum_hi   = sum[2*DATA_W:DATA_W-1];
  assign in_range = (&sum_hi) || (~|sum_hi);

  always_comb begin
    if (in_range) begin
      sum_sat = sum[DATA_W-1:0];
    end else if (sum[2*DATA_W]) begin
      sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // Horner step registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_reg <= eval_time;
      acc   <= coef_sel;
      flag  <= 1'b0;
    end
    if (cmd.mul) begin
      prod <= acc * t_reg;
    end
    if (cmd.add) begin
      acc  <= sum_sat;
      flag <= flag | ~in_range;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      poly_value <= acc;
      saturated  <= flag;
    end
  end

endmodule

/* rtl/phe_ctrl.sv */
// ----------------------------------------------------------------------------
// phe_ctrl
// Controller: sequences load, multiply, add and output-load steps and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module phe_ctrl #(
  parameter int MAX_DEGREE = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  phe_pkg::phe_stat_t stat,
  output phe_pkg::phe_cmd_t  cmd
);
  import phe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [SEL_W-1:0] idx;
  logic [SEL_W-1:0] idx_next;
  logic [SEL_W-1:0] deg_c;
  logic             out_valid_next;

  // Degree above the supported maximum acts as the maximum
  assign deg_c = (stat.degree > DEG_W'(MAX_DEGREE)) ? SEL_W'(MAX_DEGREE)
                                                    : SEL_W'(stat.degree);

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        cmd.sel = deg_c;
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = deg_c;
          state_next = (deg_c == '0) ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        cmd.sel    = idx - 1'b1;
        idx_next   = idx - 1'b1;
        state_next = (idx == SEL_W'(1)) ? S_FIN : S_MUL;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/polynomial_horner_evaluator.sv */
// ----------------------------------------------------------------------------
// polynomial_horner_evaluator
// Evaluates a configured polynomial (degree up to MAX_DEGREE) at a fixed-point
// time by Horner's rule with one shared multiplier and a saturating sum.
//
//   channel  dir  signals                         transfer
//   sample   in   valid ready eval_time           valid && ready
//   result   out  valid ready poly_value saturated valid && ready
//   cfg      in   cfg_we cfg_index cfg_data       cfg_we
//
// An item of degree d goes through a load step, a multiply step and an add
// step for each Horner step, and a final step that moves the sum to the
// output register once that register is free. The next request is taken only
// after that, so the block does not overlap items on its single multiplier.
// Reset clears the degree and all coefficients and empties the result
// register. A stalled result holds the finished sum until the output frees.
// ----------------------------------------------------------------------------
module polynomial_horner_evaluator #(
  parameter int MAX_DEGREE = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [phe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [phe_pkg::CFG_DATA_W-1:0] cfg_data,
  phe_sample_if.sink                     sample,
  phe_result_if.source                   result
);
  import phe_pkg::*;

  phe_cmd_t  cmd;
  phe_stat_t stat;

  // Sequencer
  phe_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Arithmetic and registers
  phe_dp #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .eval_time  (sample.eval_time),
    .cmd        (cmd),
    .stat       (stat),
    .poly_value (result.poly_value),
    .saturated  (result.saturated)
  );

endmodule

/* tb/polynomial_horner_evaluator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_horner_evaluator_tb
// Self-checking bench for the Horner polynomial evaluator. Loads coefficient
// sets through the register port while the block is idle and sends time
// requests with random gaps and result stalls. Each result is checked
// against a local fixed-point Horner predictor that saturates each step.
// ----------------------------------------------------------------------------
module polynomial_horner_evaluator_tb;
  import phe_pkg::*;

  localparam int     MAX_DEG      = 6;
  localparam int     FRAC         = 16;
  localparam int     NUM_COEFF    = MAX_DEG + 1;
  localparam int     SETTLE_CYC   = 2 * MAX_DEG + 4;
  localparam int     IDLE_LIMIT   = 3000;
  localparam int     RAND_PHASES  = 16;
  localparam int     RAND_ITEMS   = 55;
  localparam longint SUM_MAX      = 64'sd2147483647;
  localparam longint SUM_MIN      = -64'sd2147483648;

  typedef struct {
    data_t value;
    logic  sat;
  } horner_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  phe_sample_if smp ();
  phe_result_if res ();

  polynomial_horner_evaluator #(
    .MAX_DEGREE (MAX_DEG),
    .FRAC_BITS  (FRAC)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (smp),
    .result    (res)
  );

  // Mirror of the register file
  logic [DEG_W-1:0] poly_degree;
  data_t            coeff_reg [NUM_COEFF];
  data_t            coeff_plan [NUM_COEFF];

  horner_result_t pending_values [$];

  bit steady_flow;
  int receiver_hold_cycles;
  int err_count;
  int n_sent;
  int n_checked;
  int n_saturated;
  int n_sets;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Horner evaluation at the block's widths, saturating every step
  function automatic horner_result_t horner_eval(input data_t t);
    horner_result_t r;
    longint acc;
    longint prod;
    longint sum;
    int     eff_deg;
    eff_deg = (int'(poly_degree) > MAX_DEG) ? MAX_DEG : int'(poly_degree);
    acc = longint'(coeff_reg[eff_deg]);
    r.sat = 1'b0;
    for (int i = eff_deg - 1; i >= 0; i--) begin
      prod = acc * longint'(t);
      sum  = longint'(coeff_reg[i]) + (prod >>> FRAC);
      if (sum > SUM_MAX) begin
        sum = SUM_MAX;
        r.sat = 1'b1;
      end else if (sum < SUM_MIN) begin
        sum = SUM_MIN;
        r.sat = 1'b1;
      end
      acc = sum;
    end
    r.value = data_t'(acc[31:0]);
    return r;
  endfunction

  // Q16.16 value: tame stays within +/-2.0, otherwise full range and extremes
  function automatic data_t pick_q16(input bit tame);
    int    small_v;
    data_t v;
    small_v = int'($urandom_range(0, 262143)) - 131072;
    if (tame) begin
      v = data_t'(small_v);
    end else begin
      case ($urandom_range(0, 5))
        0: v = 32'sh7FFFFFFF;
        1: v = 32'sh80000000;
        2: v = data_t'(small_v);
        default: v = data_t'($urandom());
      endcase
    end
    return v;
  endfunction

  // Drop valid, wait for every outstanding result, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    smp.valid = 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    if (idx == REG_POLY_DEGREE) poly_degree = data[DEG_W-1:0];
    else coeff_reg[int'(idx - REG_COEFF_BASE)] = data;
  endtask

  // Load degree and coeff_plan; upper bits of the degree write are junk
  task automatic load_poly(input logic [DEG_W-1:0] deg);
    wait_idle();
    for (int k = 0; k < NUM_COEFF; k++) begin
      write_reg(CFG_IDX_W'(REG_COEFF_BASE + k), coeff_plan[k]);
    end
    write_reg(REG_POLY_DEGREE, ($urandom() & ~32'h7) | deg);
    @(negedge clk);
    cfg_we = 1'b0;
    n_sets++;
  endtask

  // One request; returns right after the accepting edge
  task automatic send_time(input data_t t);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      smp.valid = 1'b0;
    end
    @(negedge clk);
    smp.valid     = 1'b1;
    smp.eval_time = t;
    @(posedge clk);
    while (smp.ready !== 1'b1) @(posedge clk);
    pending_values.push_back(horner_eval(t));
    n_sent++;
  endtask

  // Registers are all zero after reset: every time gives zero
  task automatic test_reset_state();
    send_time(32'sh7FFFFFFF);
    send_time(32'sh80000000);
  endtask

  // 1.0 + 2.0*t across the time extremes, both saturation directions
  task automatic test_linear_extremes();
    coeff_plan = '{32'sh00010000, 32'sh00020000, 0, 0, 0, 0, 0};
    load_poly(3'd1);
    send_time(32'sh00000000);
    send_time(32'sh00010000);
    send_time(32'shFFFFFFFF);
    send_time(32'sh7FFFFFFF);
    send_time(32'sh80000000);
  endtask

  // Degree six with extreme coefficients
  task automatic test_full_degree_saturation();
    for (int k = 0; k < NUM_COEFF; k++) coeff_plan[k] = 32'sh7FFFFFFF;
    load_poly(3'd6);
    send_time(32'sh7FFFFFFF);
    send_time(32'sh80000000);
    send_time(32'sh00000000);
    send_time(32'sh00010000);
    for (int k = 0; k < NUM_COEFF; k++) coeff_plan[k] = 32'sh80000000;
    load_poly(3'd6);
    send_time(32'sh80000000);
    send_time(32'sh00010000);
  endtask

  // Degree 7 is treated as the top degree
  task automatic test_degree_clamp();
    for (int k = 0; k < NUM_COEFF; k++) coeff_plan[k] = pick_q16(1'b1);
    coeff_plan[MAX_DEG] = 32'sh00018000;
    load_poly(3'd7);
    send_time(32'sh00010000);
    send_time(32'sh00018000);
    send_time(32'shFFFE0000);
  endtask

  // Degree zero returns coeff_0; higher coefficients are ignored
  task automatic test_constant_only();
    for (int k = 0; k < NUM_COEFF; k++) coeff_plan[k] = pick_q16(1'b0);
    coeff_plan[0] = 32'sh80000000;
    coeff_plan[1] = 32'sh7FFFFFFF;
    load_poly(3'd0);
    send_time(32'sh7FFFFFFF);
    send_time(32'sh12345678);
  endtask

  // Product shift rounds toward minus infinity
  task automatic test_floor_truncation();
    coeff_plan = '{0, 32'sh00000001, 0, 0, 0, 0, 0};
    load_poly(3'd1);
    send_time(32'shFFFFFFFF);
    send_time(32'sh00000001);
    send_time(32'sh80000000);
  endtask

  // Receiver holds off while the sender keeps pushing back to back
  task automatic test_backpressure();
    for (int k = 0; k < NUM_COEFF; k++) coeff_plan[k] = pick_q16(1'b1);
    load_poly(3'd6);
    steady_flow          = 1'b1;
    receiver_hold_cycles = 300;
    for (int n = 0; n < 12; n++) send_time(pick_q16(1'b1));
    steady_flow = 1'b0;
  endtask

  // Random coefficient sets; first phases sweep every degree
  task automatic test_random_polys();
    logic [DEG_W-1:0] deg;
    bit               tame;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tame = (ph % 2) == 1;
      deg  = (ph < 8) ? ph[DEG_W-1:0] : DEG_W'($urandom_range(0, 7));
      for (int k = 0; k < NUM_COEFF; k++) coeff_plan[k] = pick_q16(tame);
      load_poly(deg);
      steady_flow = (ph % 4) == 3;
      for (int n = 0; n < RAND_ITEMS; n++) send_time(pick_q16(tame));
      steady_flow = 1'b0;
    end
  endtask

  // Result sink: random stalls, checks each result against the oldest request
  initial begin : result_sink
    int             stall;
    horner_result_t want;
    res.ready = 1'b0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (receiver_hold_cycles > 0) begin
        stall = receiver_hold_cycles;
        receiver_hold_cycles = 0;
      end
      repeat (stall) begin
        @(negedge clk);
        res.ready = 1'b0;
      end
      @(negedge clk);
      res.ready = 1'b1;
      @(posedge clk);
      while (res.valid !== 1'b1) @(posedge clk);
      if (pending_values.size() == 0) begin
        $display("%0t: unexpected result poly_value=%h saturated=%b",
                 $time, res.poly_value, res.saturated);
        err_count++;
      end else begin
        want = pending_values.pop_front();
        if (res.poly_value !== want.value) begin
          $display("%0t: poly_value mismatch expected %h actual %h",
                   $time, want.value, res.poly_value);
          err_count++;
        end
        if (res.saturated !== want.sat) begin
          $display("%0t: saturated mismatch expected %b actual %b",
                   $time, want.sat, res.saturated);
          err_count++;
        end
        if (want.sat) n_saturated++;
      end
      n_checked++;
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (smp.valid && smp.ready) || (res.valid && res.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    smp.valid            = 1'b0;
    smp.eval_time        = '0;
    steady_flow          = 1'b0;
    receiver_hold_cycles = 0;
    err_count            = 0;
    n_sent               = 0;
    n_checked            = 0;
    n_saturated          = 0;
    n_sets               = 0;
    poly_degree          = '0;
    for (int k = 0; k < NUM_COEFF; k++) coeff_reg[k] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_linear_extremes();
    test_full_degree_saturation();
    test_degree_clamp();
    test_constant_only();
    test_floor_truncation();
    test_backpressure();
    test_random_polys();

    wait_idle();
    if (pending_values.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_values.size());
      err_count++;
    end
    $display("Evaluated %0d times over %0d coefficient sets, degrees 0 to 7.",
             n_sent, n_sets);
    $display("Checked %0d results (%0d saturated), %0d mismatches.",
             n_checked, n_saturated, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/phe_pkg.sv
rtl/phe_if.sv
rtl/phe_dp.sv
rtl/phe_ctrl.sv
rtl/polynomial_horner_evaluator.sv
tb/polynomial_horner_evaluator_tb.sv
